[sv/at_response_terminator_detector_core_macros.svh]
// Assertion macros shared by the AT response terminator detector.
`ifndef AT_RESPONSE_TERMINATOR_DETECTOR_CORE_MACROS_SVH
`define AT_RESPONSE_TERMINATOR_DETECTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATRTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATRTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[sv/atrtd_pkg.sv]
// Types, codes and result code patterns of the AT response terminator detector.
package atrtd_pkg;

  localparam int WinBytes  = 16;
  localparam int CodeCount = 8;
  localparam int IdxW      = 3;
  localparam int CountW    = 16;
  localparam int TimeoutW  = 16;
  localparam int ByteW     = 8;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd10;

  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;

  typedef logic [8*WinBytes-1:0] window_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic {
    STATUS_MATCH   = 1'b0,
    STATUS_TIMEOUT = 1'b1
  } status_e;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } match_t;

  // Patterns are right-aligned: the last character sits in the lowest byte.
  localparam window_t CODE_TEXT [CodeCount] = '{
    window_t'({CR, LF, "OK", CR, LF}),
    window_t'({CR, LF, "CONNECT", CR, LF}),
    window_t'({CR, LF, "RING", CR, LF}),
    window_t'({CR, LF, "NO CARRIER", CR, LF}),
    window_t'({CR, LF, "ERROR", CR, LF}),
    window_t'({CR, LF, "NO DIALTONE", CR, LF}),
    window_t'({CR, LF, "BUSY", CR, LF}),
    window_t'({CR, LF, "NO ANSWER", CR, LF})
  };

  localparam int CODE_LEN [CodeCount] = '{6, 11, 8, 14, 9, 15, 8, 13};

endpackage

[sv/atrtd_matcher.sv]
// Parallel compare of the byte window against all final result codes.
module atrtd_matcher (
  input  atrtd_pkg::window_t window_i,
  output atrtd_pkg::match_t  match_o
);

  logic [atrtd_pkg::CodeCount-1:0] hit;

  for (genvar k = 0; k < atrtd_pkg::CodeCount; k++) begin : g_code
    localparam atrtd_pkg::window_t Mask =
      atrtd_pkg::window_t'({(8*atrtd_pkg::WinBytes){1'b1}})
      >> (8 * (atrtd_pkg::WinBytes - atrtd_pkg::CODE_LEN[k]));
    assign hit[k] = ((window_i ^ atrtd_pkg::CODE_TEXT[k]) & Mask) == '0;
  end

  // The lowest matching index wins.
  always_comb begin
    match_o.hit = 1'b0;
    match_o.idx = '0;
    for (int k = atrtd_pkg::CodeCount - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match_o.hit = 1'b1;
        match_o.idx = atrtd_pkg::IdxW'(k);
      end
    end
  end

endmodule

[sv/at_response_terminator_detector_core.sv]
// Top level of the AT response terminator detector.
// The slave stream carries one item per transfer: tuser holds the action
// (start, received byte, one-second tick) and tdata the received byte.
// A start transfer arms the block and clears its window, timer and count.
// While armed, a byte whose arrival completes a final result code gives one
// result transfer with the code index and the byte count, and disarms.
// While armed, a tick that lifts the elapsed seconds above the timeout gives
// a timeout result and disarms. Other items give no result.
// The timeout register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
// An item goes through an input register and then a result register before
// its result is offered on the master side. One item is taken in every
// cycle unless the master side stalls; the window compare and update are
// combinational. When the master side stalls, the result register holds
// and one more item waits in the input register before s_axis_tready drops.
// After reset the block is disarmed, the window, timer and count are zero
// and the timeout is ten seconds.
`include "at_response_terminator_detector_core_macros.svh"

module at_response_terminator_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] code_index, [18:3] byte_count, rest zero
  output logic        m_axis_tuser,   // [0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] timeout_seconds
);

  logic                           in_valid_q, in_valid_d;
  logic [1:0]                     in_action_q;
  logic [atrtd_pkg::ByteW-1:0]    in_byte_q;

  atrtd_pkg::window_t             window_q, window_d, window_shift;
  logic [atrtd_pkg::TimeoutW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [atrtd_pkg::CountW-1:0]   count_q, count_d, count_inc;
  logic                           armed_q, armed_d;
  logic [atrtd_pkg::TimeoutW-1:0] timeout_q;

  logic                           out_valid_q, out_valid_d;
  logic                           out_status_q;
  logic [atrtd_pkg::IdxW-1:0]     out_idx_q;
  logic [atrtd_pkg::CountW-1:0]   out_count_q;

  logic                           advance;
  logic                           res_valid;
  logic                           res_status;
  logic [atrtd_pkg::IdxW-1:0]     res_idx;
  atrtd_pkg::match_t              match;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign window_shift = {window_q[8*atrtd_pkg::WinBytes-9:0], in_byte_q};
  assign elapsed_inc  = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign count_inc    = (count_q != '1) ? count_q + 1'b1 : count_q;

  atrtd_matcher u_matcher (
    .window_i (window_shift),
    .match_o  (match)
  );

  always_comb begin
    window_d   = window_q;
    elapsed_d  = elapsed_q;
    count_d    = count_q;
    armed_d    = armed_q;
    res_valid  = 1'b0;
    res_status = atrtd_pkg::STATUS_MATCH;
    res_idx    = '0;
    if (advance) begin
      case (in_action_q)
        atrtd_pkg::ACT_START: begin
          window_d  = '0;
          elapsed_d = '0;
          count_d   = '0;
          armed_d   = 1'b1;
        end
        atrtd_pkg::ACT_BYTE: begin
          if (armed_q) begin
            window_d = window_shift;
            count_d  = count_inc;
            if (match.hit) begin
              armed_d   = 1'b0;
              res_valid = 1'b1;
              res_idx   = match.idx;
            end
          end
        end
        atrtd_pkg::ACT_TICK: begin
          if (armed_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc > timeout_q) begin
              armed_d    = 1'b0;
              res_valid  = 1'b1;
              res_status = atrtd_pkg::STATUS_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
      elapsed_q   <= '0;
      count_q     <= '0;
      armed_q     <= 1'b0;
      timeout_q   <= atrtd_pkg::TimeoutReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      window_q    <= window_d;
      elapsed_q   <= elapsed_d;
      count_q     <= count_d;
      armed_q     <= armed_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_status_q <= res_status;
      out_idx_q    <= res_idx;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'd0, out_count_q, out_idx_q};

  `ATRTD_ASSERT_SAME(a_result_needs_armed, advance && res_valid, armed_q,
    "result produced while disarmed")
  `ATRTD_ASSERT_NEXT(a_result_disarms, advance && res_valid, !armed_q,
    "block still armed after a result")
  `ATRTD_ASSERT_SAME(a_full_stall_blocks, in_valid_q && out_valid_q && !m_axis_tready,
    !s_axis_tready, "input accepted while both registers are full")
  `ATRTD_ASSERT_SAME(a_timeout_index_zero,
    m_axis_tvalid && (m_axis_tuser == atrtd_pkg::STATUS_TIMEOUT),
    m_axis_tdata[2:0] == '0, "timeout result with nonzero code index")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the AT response terminator detector core.
`timescale 1ns / 1ps

module tb_top;
  import atrtd_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    status_e     status;
    logic [2:0]  code_idx;
    logic [15:0] count;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = ACT_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'h0000;

  string       code_body [8] = '{"OK", "CONNECT", "RING", "NO CARRIER", "ERROR",
                                 "NO DIALTONE", "BUSY", "NO ANSWER"};

  logic [7:0]  rx_window [16];
  logic [15:0] secs_elapsed;
  logic [15:0] bytes_seen;
  logic [15:0] timeout_setting;
  bit          detector_armed;
  report_t     expected_reports [$];

  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_cycles = 0;
  int          items_sent = 0;
  int          errors = 0;

  at_response_terminator_detector_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] framed_char(int k, int pos);
    int n;
    n = code_body[k].len() + 4;
    if (pos == 0 || pos == n - 2) return CR;
    if (pos == 1 || pos == n - 1) return LF;
    return code_body[k][pos-2];
  endfunction

  function automatic bit window_ends_with(int k);
    int n;
    n = code_body[k].len() + 4;
    for (int i = 0; i < n; i++) begin
      if (rx_window[16-n+i] !== framed_char(k, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_detector(logic [1:0] act, logic [7:0] data);
    report_t rpt;
    bit      hit;
    hit = 1'b0;
    case (act)
      ACT_START: begin
        for (int i = 0; i < 16; i++) rx_window[i] = 8'h00;
        secs_elapsed = '0;
        bytes_seen = '0;
        detector_armed = 1'b1;
      end
      ACT_BYTE: if (detector_armed) begin
        if (bytes_seen != 16'hffff) bytes_seen++;
        for (int i = 0; i < 15; i++) rx_window[i] = rx_window[i+1];
        rx_window[15] = data;
        for (int k = 0; k < 8; k++) begin
          if (!hit && window_ends_with(k)) begin
            hit = 1'b1;
            rpt = '{STATUS_MATCH, 3'(k), bytes_seen};
          end
        end
      end
      ACT_TICK: if (detector_armed) begin
        if (secs_elapsed != 16'hffff) secs_elapsed++;
        if (secs_elapsed > timeout_setting) begin
          hit = 1'b1;
          rpt = '{STATUS_TIMEOUT, 3'd0, bytes_seen};
        end
      end
      default: ;
    endcase
    if (hit) begin
      detector_armed = 1'b0;
      expected_reports.push_back(rpt);
    end
  endtask

  task automatic send_item(logic [1:0] act, logic [7:0] data);
    while (!no_gaps && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_detector(act, data);
    items_sent++;
  endtask

  task automatic send_code(int k, int n_chars);
    for (int i = 0; i < n_chars; i++) send_item(ACT_BYTE, framed_char(k, i));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_setting = value;
    @(posedge clk_i);
  endtask

  task automatic send_response();
    int shape;
    int k;
    int ticks;
    shape = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    ticks = (timeout_setting < 24) ? int'(timeout_setting) + 1 : 24;
    send_item(ACT_START, 8'($urandom));
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 5) == 0) send_item(ACT_TICK, 8'($urandom));
      else send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end
    if (shape < 65) begin
      send_code(k, code_body[k].len() + 4);
    end else if (shape < 80) begin
      repeat (ticks) send_item(ACT_TICK, 8'($urandom));
    end else if (shape < 90) begin
      send_code(k, $urandom_range(1, code_body[k].len() + 3));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(1, 3)), 8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(1, 3)), 8'($urandom));
    end
  endtask

  task automatic run_random_phase(int n_items);
    int stop;
    stop = items_sent + n_items;
    while (items_sent < stop) send_response();
    wait_idle();
  endtask

  task automatic test_disarmed_and_restart();
    send_item(ACT_BYTE, 8'hff);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_RESERVED, 8'hff);
    send_item(ACT_START, 8'h00);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hff);
    send_item(ACT_RESERVED, 8'hff);
    send_code(0, 5);
    send_item(ACT_START, 8'hff);
    send_item(ACT_BYTE, LF);
    send_code(0, 6);
    send_item(ACT_BYTE, "A");
    send_item(ACT_TICK, 8'h55);
    wait_idle();
  endtask

  task automatic test_zero_timeout();
    write_timeout(16'd0);
    send_item(ACT_START, 8'haa);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (40) begin
      send_item(ACT_START, 8'($urandom));
      send_item(ACT_TICK, 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [15:0] settings [6];
    settings = '{16'd1, 16'd7, 16'($urandom_range(2, 30)), 16'hffff, 16'd0, 16'd3};
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      no_gaps = (i == 2);
      run_random_phase(240);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    report_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: status %0d code_index %0d byte_count %0d",
               m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3]);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[2:0] !== exp_r.code_idx) begin
          $error("code_index: expected %0d, got %0d", exp_r.code_idx, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[18:3] !== exp_r.count) begin
          $error("byte_count: expected %0d, got %0d", exp_r.count, m_axis_tdata[18:3]);
          errors++;
        end
        if (m_axis_tdata[23:19] !== 5'd0) begin
          $error("tdata padding: expected 0, got %0d", m_axis_tdata[23:19]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) rx_window[i] = 8'h00;
    secs_elapsed = '0;
    bytes_seen = '0;
    detector_armed = 1'b0;
    timeout_setting = TimeoutReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disarmed_and_restart();
    run_random_phase(120);
    test_zero_timeout();
    test_output_backpressure();
    test_random_settings();
    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
